FILE: hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fcsg_pkg.sv
package fcsg_pkg;

  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 5;
  localparam int MASK_W   = 8;
  localparam int ROW_W    = 11;
  localparam int DIM_W    = 12;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = REG_IDX_W'(1);

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(320);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(200);
  localparam logic [DIM_W-1:0] DIM_MAX      = DIM_W'(2048);

  localparam int MAX_RADIUS_DEF = 31;

endpackage

FILE: hdl/fcsg_if.sv
interface fcsg_cmd_if import fcsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic [RADIUS_W-1:0]       radius;
  logic [MASK_W-1:0]         pixel_mask;

  modport source (output valid, output center_x, output center_y, output radius,
                  output pixel_mask, input ready);
  modport sink (input valid, input center_x, input center_y, input radius,
                input pixel_mask, output ready);
endinterface

interface fcsg_span_if import fcsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  span_row;
  logic [ROW_W-1:0]  span_first;
  logic [ROW_W-1:0]  span_last;
  logic [MASK_W-1:0] span_mask;
  logic              final_span;

  modport source (output valid, output span_row, output span_first, output span_last,
                  output span_mask, output final_span, input ready);
  modport sink (input valid, input span_row, input span_first, input span_last,
                input span_mask, input final_span, output ready);
endinterface

FILE: hdl/filled_circle_span_generator_unit.sv
// Filled circle span generator. Each command transfer (signed centre, radius, OR mask)
// yields one horizontal span per visible row of the circle, clipped to the screen size
// held in two APB registers (screen_width at 0x0, screen_height at 0x4). Rows whose span
// is empty after clipping produce nothing, and the last span of a circle carries
// final_span. A command occupies the row counter for one cycle per visible row while the
// output is not stalled, and the next command is taken in the cycle after its last row
// has been issued; a circle with no visible row does not occupy the row counter at all.
// Rows flow through $clog2(MAX_RADIUS+1)+3 pipeline stages (distance, remainder, one
// square root bit per stage, clipping), then a look-ahead register that decides the
// final flag, and then the output register. The last span of a circle waits in the
// look-ahead register until the circle's last row has been clipped.
`include "assert_macros.svh"

module filled_circle_span_generator_unit import fcsg_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  fcsg_cmd_if.sink           cmd,
  fcsg_span_if.source        span
);

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int R2W   = 2 * RW;
  localparam int EXT_W = COORD_W + 2;
  localparam logic [RADIUS_W-1:0]    MAX_R_IN = RADIUS_W'(MAX_RADIUS);
  localparam logic signed [EXT_W-1:0] ONE_S   = EXT_W'(1);

  typedef struct packed {
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [COORD_W-1:0] cx;
    logic [MASK_W-1:0] mask;
  } tag_t;

  // Configuration registers.
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height);
      default:           prdata = '0;
    endcase
  end

  logic [DIM_W-1:0]        w_clamp;
  logic [DIM_W-1:0]        h_clamp;
  logic signed [EXT_W-1:0] wlim;
  logic signed [EXT_W-1:0] hlim;

  assign w_clamp = (screen_width > DIM_MAX) ? DIM_MAX : screen_width;
  assign h_clamp = (screen_height > DIM_MAX) ? DIM_MAX : screen_height;
  assign wlim    = signed'(EXT_W'(w_clamp)) - ONE_S;
  assign hlim    = signed'(EXT_W'(h_clamp)) - ONE_S;

  // Command decode and row range.
  logic                     busy;
  logic                     adv;
  logic                     cmd_fire;
  logic [RADIUS_W-1:0]      r_sat;
  logic [RW-1:0]            r_in;
  logic signed [EXT_W-1:0]  cy_ext;
  logic signed [EXT_W-1:0]  r_ext;
  logic signed [EXT_W-1:0]  y0_raw;
  logic signed [EXT_W-1:0]  y1_raw;
  logic signed [EXT_W-1:0]  y0_c;
  logic signed [EXT_W-1:0]  y1_c;
  logic                     rows_none;

  assign cmd.ready = !rst && !busy;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign r_sat     = (cmd.radius > MAX_R_IN) ? MAX_R_IN : cmd.radius;
  assign r_in      = r_sat[RW-1:0];
  assign cy_ext    = EXT_W'(cmd.center_y);
  assign r_ext     = signed'(EXT_W'(r_in));
  assign y0_raw    = cy_ext - r_ext;
  assign y1_raw    = cy_ext + r_ext;
  assign y0_c      = (y0_raw < 0) ? '0 : y0_raw;
  assign y1_c      = (y1_raw > hlim) ? hlim : y1_raw;
  assign rows_none = y0_c > y1_c;

  logic [ROW_W-1:0]          current_row;
  logic [ROW_W-1:0]          end_row;
  logic signed [COORD_W-1:0] held_center_x;
  logic signed [COORD_W-1:0] held_center_y;
  logic [R2W-1:0]            held_radius_sq;
  logic [MASK_W-1:0]         held_mask;
  logic                      row_is_last;

  assign row_is_last = current_row == end_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      current_row <= '0;
      end_row     <= '0;
    end else if (cmd_fire) begin
      busy        <= !rows_none;
      current_row <= rows_none ? '0 : y0_c[ROW_W-1:0];
      end_row     <= rows_none ? '0 : y1_c[ROW_W-1:0];
    end else if (busy && adv) begin
      current_row <= current_row + ROW_W'(1);
      if (row_is_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x  <= '0;
      held_center_y  <= '0;
      held_radius_sq <= '0;
      held_mask      <= '0;
    end else if (cmd_fire) begin
      held_center_x  <= cmd.center_x;
      held_center_y  <= cmd.center_y;
      held_radius_sq <= R2W'(r_in) * R2W'(r_in);
      held_mask      <= cmd.pixel_mask;
    end
  end

  // Stage A: distance from the centre row.
  logic signed [EXT_W-1:0] dy_full;
  logic signed [EXT_W-1:0] dy_abs;
  logic                    a_valid;
  tag_t                    a_tag;
  logic [RW-1:0]           a_adx;
  logic [R2W-1:0]          a_r2;

  assign dy_full = signed'(EXT_W'(current_row)) - EXT_W'(held_center_y);
  assign dy_abs  = (dy_full < 0) ? -dy_full : dy_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid    <= busy;
      a_tag.last <= row_is_last;
      a_tag.row  <= current_row;
      a_tag.cx   <= held_center_x;
      a_tag.mask <= held_mask;
      a_adx      <= dy_abs[RW-1:0];
      a_r2       <= held_radius_sq;
    end
  end

  // Stage B and the square root stages, one result bit per stage, most significant first.
  logic           sq_valid [RW+1];
  tag_t           sq_tag   [RW+1];
  logic [R2W-1:0] sq_v     [RW+1];
  logic [RW-1:0]  sq_s     [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= a_valid;
      sq_tag[0]   <= a_tag;
      sq_v[0]     <= a_r2 - R2W'(a_adx) * R2W'(a_adx);
      sq_s[0]     <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW-1:0]  trial;
    logic [R2W-1:0] trial_sq;

    assign trial    = sq_s[k] | RW'(1 << (RW - 1 - k));
    assign trial_sq = R2W'(trial) * R2W'(trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[k+1] <= sq_valid[k];
        sq_tag[k+1]   <= sq_tag[k];
        sq_v[k+1]     <= sq_v[k];
        sq_s[k+1]     <= (trial_sq <= sq_v[k]) ? trial : sq_s[k];
      end
    end
  end

  // Stage C: horizontal extent and clipping.
  logic signed [EXT_W-1:0] cx_ext;
  logic signed [EXT_W-1:0] half_ext;
  logic signed [EXT_W-1:0] x0_raw;
  logic signed [EXT_W-1:0] x1_raw;
  logic signed [EXT_W-1:0] x0_c;
  logic signed [EXT_W-1:0] x1_c;
  logic                    c_valid;
  tag_t                    c_tag;
  logic [ROW_W-1:0]        c_first;
  logic [ROW_W-1:0]        c_last_col;
  logic                    c_nonempty;

  assign cx_ext   = EXT_W'(signed'(sq_tag[RW].cx));
  assign half_ext = signed'(EXT_W'(sq_s[RW]));
  assign x0_raw   = cx_ext - half_ext;
  assign x1_raw   = cx_ext + half_ext;
  assign x0_c     = (x0_raw < 0) ? '0 : x0_raw;
  assign x1_c     = (x1_raw > wlim) ? wlim : x1_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid    <= sq_valid[RW];
      c_tag      <= sq_tag[RW];
      c_first    <= x0_c[ROW_W-1:0];
      c_last_col <= x1_c[ROW_W-1:0];
      c_nonempty <= x0_c <= x1_c;
    end
  end

  // Look-ahead register: a span is released once the next visible span of the same
  // circle arrives, or once the circle's last row shows that none will follow.
  logic             p_valid;
  logic             p_final;
  logic [ROW_W-1:0] p_row;
  logic [ROW_W-1:0] p_first;
  logic [ROW_W-1:0] p_last_col;
  logic [MASK_W-1:0] p_mask;
  logic             out_free;
  logic             pend_emit;
  logic             c_take;

  assign out_free  = !span.valid || span.ready;
  assign pend_emit = p_valid && (p_final || (c_valid && c_nonempty)) && out_free;
  assign c_take    = c_valid && (!c_nonempty || !p_valid || pend_emit);
  assign adv       = !c_valid || c_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_final <= 1'b0;
    end else if (c_take && c_nonempty) begin
      p_valid <= 1'b1;
      p_final <= c_tag.last;
    end else if (c_take && c_tag.last && p_valid && !p_final) begin
      p_final <= 1'b1;
    end else if (pend_emit) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_take && c_nonempty) begin
      p_row      <= c_tag.row;
      p_first    <= c_first;
      p_last_col <= c_last_col;
      p_mask     <= c_tag.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span.valid <= 1'b0;
    end else if (pend_emit) begin
      span.valid <= 1'b1;
    end else if (span.ready) begin
      span.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_emit) begin
      span.span_row   <= p_row;
      span.span_first <= p_first;
      span.span_last  <= p_last_col;
      span.span_mask  <= p_mask;
      span.final_span <= p_final;
    end
  end

  `ASSERT_NEXT(a_busy_ends, clk, rst, busy && adv && row_is_last, !busy, "row counter ran past the last row")
  `ASSERT_IMPL(a_row_bound, clk, rst, busy, current_row <= end_row, "current row beyond end row")
  `ASSERT_NEXT(a_cmd_starts, clk, rst, cmd_fire && !rows_none, busy && (current_row == $past(y0_c[ROW_W-1:0])), "command did not start at its first row")
  `ASSERT_IMPL(a_nonfinal_successor, clk, rst, pend_emit && !p_final, c_take && c_nonempty, "non-final span released without a successor")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fcsg_pkg::*;

  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0]       radius;
    logic [MASK_W-1:0]         mask;
  } circle_t;

  typedef struct {
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  first_col;
    logic [ROW_W-1:0]  last_col;
    logic [MASK_W-1:0] mask;
    logic              fin;
  } span_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fcsg_cmd_if  cmd_bus ();
  fcsg_span_if span_bus ();

  filled_circle_span_generator_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_bus),
    .span    (span_bus)
  );

  logic [DIM_W-1:0] screen_width  = RESET_WIDTH;
  logic [DIM_W-1:0] screen_height = RESET_HEIGHT;

  circle_t circle_queue[$];
  span_t   expected_spans[$];
  circle_t circle_on_bus;
  span_t   head_span;

  int  circles_queued   = 0;
  int  circles_accepted = 0;
  int  spans_checked    = 0;
  int  screen_sizes     = 1;
  int  errors           = 0;
  int  send_gap         = 0;
  int  stall_left       = 0;
  bit  idling_on        = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Expected spans of one circle under the current screen size.
  function automatic void rasterize_circle(input circle_t c);
    int cx, cy, r, rsq, w, h, top, bottom, y, dy, rem, half, left, right;
    span_t s;
    span_t row_spans[$];
    cx = c.cx;
    cy = c.cy;
    r = c.radius;
    if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
    rsq = r * r;
    w = (screen_width > DIM_MAX) ? int'(DIM_MAX) : int'(screen_width);
    h = (screen_height > DIM_MAX) ? int'(DIM_MAX) : int'(screen_height);
    top = cy - r;
    bottom = cy + r;
    if (top < 0) top = 0;
    if (bottom > h - 1) bottom = h - 1;
    for (y = top; y <= bottom; y++) begin
      dy = y - cy;
      rem = rsq - dy * dy;
      half = 0;
      while ((half + 1) * (half + 1) <= rem) half++;
      left = cx - half;
      right = cx + half;
      if (left < 0) left = 0;
      if (right > w - 1) right = w - 1;
      if (left <= right) begin
        s.row = ROW_W'(y);
        s.first_col = ROW_W'(left);
        s.last_col = ROW_W'(right);
        s.mask = c.mask;
        s.fin = 1'b0;
        row_spans.push_back(s);
      end
    end
    if (row_spans.size() > 0) begin
      s = row_spans.pop_back();
      s.fin = 1'b1;
      row_spans.push_back(s);
    end
    foreach (row_spans[i]) expected_spans.push_back(row_spans[i]);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic circle_t random_circle();
    circle_t c;
    int w, h;
    w = (screen_width > DIM_MAX) ? int'(DIM_MAX) : int'(screen_width);
    h = (screen_height > DIM_MAX) ? int'(DIM_MAX) : int'(screen_height);
    if ($urandom_range(0, 4) == 0) begin
      c.cx = COORD_W'($urandom);
      c.cy = COORD_W'($urandom);
    end else begin
      c.cx = COORD_W'($urandom_range(0, w + 63) - 32);
      c.cy = COORD_W'($urandom_range(0, h + 63) - 32);
    end
    c.radius = RADIUS_W'($urandom);
    c.mask = MASK_W'($urandom);
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        rasterize_circle(circle_on_bus);
        circles_accepted++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (send_gap > 0 || circle_queue.size() == 0) begin
          if (send_gap > 0) send_gap--;
          cmd_bus.valid <= 1'b0;
        end else begin
          circle_on_bus = circle_queue.pop_front();
          cmd_bus.valid <= 1'b1;
          cmd_bus.center_x <= circle_on_bus.cx;
          cmd_bus.center_y <= circle_on_bus.cy;
          cmd_bus.radius <= circle_on_bus.radius;
          cmd_bus.pixel_mask <= circle_on_bus.mask;
          if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      span_bus.ready <= 1'b0;
    end else begin
      if (span_bus.valid && span_bus.ready) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected span transfer, expected none, actual row %0d cols %0d..%0d",
                   $time, span_bus.span_row, span_bus.span_first, span_bus.span_last);
          errors++;
        end else begin
          head_span = expected_spans.pop_front();
          check_field("span_row", 16'(head_span.row), 16'(span_bus.span_row));
          check_field("span_first", 16'(head_span.first_col), 16'(span_bus.span_first));
          check_field("span_last", 16'(head_span.last_col), 16'(span_bus.span_last));
          check_field("span_mask", 16'(head_span.mask), 16'(span_bus.span_mask));
          check_field("final_span", 16'(head_span.fin), 16'(span_bus.final_span));
          spans_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        span_bus.ready <= 1'b0;
      end else begin
        span_bus.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  task automatic queue_circle(input int cx, input int cy, input int radius, input int mask);
    circle_t c;
    c.cx = COORD_W'(cx);
    c.cy = COORD_W'(cy);
    c.radius = RADIUS_W'(radius);
    c.mask = MASK_W'(mask);
    circle_queue.push_back(c);
    circles_queued++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      circle_queue.push_back(random_circle());
      circles_queued++;
    end
  endtask

  // Circles that yield no span may still be sweeping rows, hence the margin.
  task automatic wait_idle();
    while (circles_accepted != circles_queued || expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) screen_width = value;
    else screen_height = value;
  endtask

  task automatic set_screen(input int w, input int h);
    write_register(REG_SCREEN_WIDTH, DIM_W'(w));
    write_register(REG_SCREEN_HEIGHT, DIM_W'(h));
    screen_sizes++;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.center_x = '0;
    cmd_bus.center_y = '0;
    cmd_bus.radius = '0;
    cmd_bus.pixel_mask = '0;
    span_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default screen: centre, corners, clipping on every side and empty spans.
    queue_circle(0, 0, 0, 8'hFF);
    queue_circle(160, 100, 31, 8'hA5);
    queue_circle(160, 100, 0, 8'h00);
    queue_circle(-2048, -2048, 31, 8'hFF);
    queue_circle(2047, 2047, 31, 8'h5A);
    queue_circle(-1, 100, 31, 8'h0F);
    queue_circle(330, 0, 31, 8'hF0);
    queue_circle(100, 199, 20, 8'h3C);
    queue_circle(-31, 50, 31, 8'h81);
    queue_circle(-32, 50, 31, 8'h7E);
    queue_circle(50, -31, 31, 8'hC3);
    queue_circle(50, -32, 31, 8'h24);
    queue_circle(319, 199, 1, 8'hFF);
    wait_idle();
    queue_random(18);
    wait_idle();

    set_screen(2048, 2048);
    queue_circle(2047, 2047, 31, 8'h99);
    queue_circle(1024, 1024, 31, 8'h66);
    queue_circle(2040, 5, 7, 8'h11);
    queue_random(14);
    wait_idle();

    idling_on = 1'b0;
    set_screen(1, 1);
    queue_circle(0, 0, 5, 8'h42);
    queue_circle(1, 0, 1, 8'hBD);
    queue_circle(2, 0, 1, 8'h18);
    queue_random(12);
    wait_idle();
    idling_on = 1'b1;

    set_screen(0, 4095);
    queue_circle(10, 10, 5, 8'hE7);
    queue_random(4);
    wait_idle();

    set_screen(4095, 0);
    queue_circle(10, 10, 5, 8'h7F);
    queue_random(4);
    wait_idle();

    repeat (3) begin
      set_screen($urandom_range(1, 2048), $urandom_range(1, 2048));
      queue_random(15);
      wait_idle();
    end

    idling_on = 1'b0;
    set_screen(320, 200);
    queue_random(12);
    wait_idle();

    $display("Checked %0d spans from %0d circles over %0d screen sizes.",
             spans_checked, circles_accepted, screen_sizes);
    $display("Screens ranged from zero and one pixel up to past the 2048 limit.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/fcsg_pkg.sv
hdl/fcsg_if.sv
hdl/filled_circle_span_generator_unit.sv
dv/testbench.sv
